[sv/ole_pkg.sv]
// Shared constants and types for the ordered list engine.
package ole_pkg;
	localparam int CAPACITY = 256;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;

	localparam logic [3:0] CMD_INS_FIRST  = 4'd0;
	localparam logic [3:0] CMD_INS_LAST   = 4'd1;
	localparam logic [3:0] CMD_INS_AT     = 4'd2;
	localparam logic [3:0] CMD_INS_BEFORE = 4'd3;
	localparam logic [3:0] CMD_DEL_FIRST  = 4'd4;
	localparam logic [3:0] CMD_DEL_LAST   = 4'd5;
	localparam logic [3:0] CMD_DEL_AT     = 4'd6;
	localparam logic [3:0] CMD_DEL_VALUE  = 4'd7;
	localparam logic [3:0] CMD_FIND       = 4'd8;
	localparam logic [3:0] CMD_READ       = 4'd9;
	localparam logic [3:0] CMD_REVERSE    = 4'd10;
	localparam logic [3:0] CMD_CLEAR      = 4'd11;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [31:0]   wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;
endpackage

[sv/ole_ram.sv]
// Single-port-write, single-port-read entry memory with registered read.
module ole_ram import ole_pkg::*; (
	input  logic        clk,
	input  mem_req_t    req,
	output logic [31:0] rdata
);
	logic [31:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

[sv/ole_seq.sv]
// Command sequencer: walks, shifts and swaps entries through the memory.
module ole_seq import ole_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [8:0]  position,
	input  logic [31:0] value,
	input  logic [31:0] target_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  found_index,
	output logic [31:0] read_value,
	output logic [8:0]  length,
	output mem_req_t    mreq,
	input  logic [31:0] rdata
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHUP  = 3'd2;
	localparam logic [2:0] S_SHDN  = 3'd3;
	localparam logic [2:0] S_REVA  = 3'd4;
	localparam logic [2:0] S_REVB  = 3'd5;
	localparam logic [2:0] S_READ  = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [3:0]    cmd_q;
	logic [31:0]   val_q, tgt_q, hold_q;
	logic [CW-1:0] i_q, j_q, idx_q;
	logic          pend_q;
	logic          ov_q;
	logic [2:0]    st_q;
	logic [7:0]    fi_q;
	logic [31:0]   rv_q;
	logic [8:0]    len_q;

	// decode of an accepted request
	logic          imm_w;
	logic [2:0]    imm_st_w;
	logic [2:0]    nxt_w;
	logic [CW-1:0] idx_w;
	logic [CW-1:0] i_w;

	logic [CW-1:0] pos_w;
	assign pos_w = CW'(position);
	assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
	wire take = in_valid && !in_stall;
	wire full = (count_q == CW'(CAPACITY));

	assign out_valid   = ov_q;
	assign status      = st_q;
	assign found_index = fi_q;
	assign read_value  = rv_q;
	assign length      = len_q;

	always_comb begin
		imm_w = 1'b1;
		imm_st_w = ST_OK;
		nxt_w = S_IDLE;
		idx_w = '0;
		i_w = '0;
		case (command)
			CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
				if (command == CMD_INS_AT && pos_w > count_q) begin
					imm_st_w = ST_BAD_INDEX;
				end else if (full) begin
					imm_st_w = ST_FULL;
				end else begin
					imm_w = 1'b0;
					nxt_w = S_SHUP;
					i_w = count_q;
					idx_w = (command == CMD_INS_FIRST) ? '0 :
						(command == CMD_INS_LAST) ? count_q : pos_w;
				end
			end
			CMD_INS_BEFORE, CMD_DEL_VALUE, CMD_FIND: begin
				if (count_q == '0) begin
					imm_st_w = ST_NOT_FOUND;
				end else begin
					imm_w = 1'b0;
					nxt_w = S_SCAN;
				end
			end
			CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
				if (command != CMD_DEL_AT && count_q == '0) begin
					imm_st_w = ST_EMPTY;
				end else if (command == CMD_DEL_AT && pos_w >= count_q) begin
					imm_st_w = ST_BAD_INDEX;
				end else begin
					imm_w = 1'b0;
					nxt_w = S_SHDN;
					i_w = ((command == CMD_DEL_FIRST) ? '0 :
						(command == CMD_DEL_LAST) ? count_q - 1'b1 : pos_w)
						+ 1'b1;
				end
			end
			CMD_READ: begin
				if (pos_w >= count_q) begin
					imm_st_w = ST_BAD_INDEX;
				end else begin
					imm_w = 1'b0;
					nxt_w = S_SCAN;
					i_w = pos_w;
				end
			end
			CMD_REVERSE: begin
				if (count_q > CW'(1)) begin
					imm_w = 1'b0;
					nxt_w = S_REVA;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		mreq = '0;
		case (state_q)
			S_SCAN: begin
				mreq.re = 1'b1;
				mreq.raddr = i_q[AW-1:0];
			end
			S_SHUP: begin
				// move entry i-1 to i, walking down toward idx
				mreq.re = (i_q != idx_q);
				mreq.raddr = AW'(i_q - 1'b1);
				mreq.we = pend_q;
				mreq.waddr = AW'(i_q);
				mreq.wdata = rdata;
				if (i_q == idx_q && !pend_q) begin
					mreq.we = 1'b1;
					mreq.wdata = val_q;
					mreq.waddr = AW'(idx_q);
				end
			end
			S_SHDN: begin
				mreq.re = (i_q < count_q);
				mreq.raddr = AW'(i_q);
				mreq.we = pend_q;
				mreq.waddr = AW'(i_q - 1'b1);
				mreq.wdata = rdata;
			end
			S_REVA: begin
				mreq.re = 1'b1;
				mreq.raddr = AW'(i_q);
			end
			S_REVB: begin
				mreq.re = 1'b1;
				mreq.raddr = AW'(j_q);
			end
			S_READ: begin
				mreq.we = 1'b1;
				if (pend_q) begin
					mreq.waddr = AW'(i_q);
					mreq.wdata = rdata;
				end else begin
					mreq.waddr = AW'(j_q);
					mreq.wdata = hold_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q    <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						cmd_q <= command;
						val_q <= value;
						tgt_q <= target_value;
						st_q <= imm_st_w;
						fi_q <= '0;
						rv_q <= '0;
						pend_q <= 1'b0;
						ov_q <= imm_w;
						idx_q <= idx_w;
						i_q <= i_w;
						j_q <= count_q - 1'b1;
						state_q <= nxt_w;
						if (command == CMD_CLEAR) begin
							count_q <= '0;
							len_q <= '0;
						end else begin
							len_q <= 9'(count_q);
						end
					end else if (ov_q && !out_stall) begin
						ov_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// read issued now; compare data next cycle via pend
					if (pend_q) begin
						if (cmd_q == CMD_READ) begin
							rv_q <= rdata; ov_q <= 1'b1; len_q <= 9'(count_q);
							pend_q <= 1'b0; state_q <= S_IDLE;
						end else if (rdata == ((cmd_q == CMD_INS_BEFORE) ? tgt_q : val_q)) begin
							pend_q <= 1'b0;
							if (cmd_q == CMD_FIND) begin
								fi_q <= 8'(idx_q); ov_q <= 1'b1; len_q <= 9'(count_q);
								state_q <= S_IDLE;
							end else if (cmd_q == CMD_DEL_VALUE) begin
								i_q <= idx_q + 1'b1; state_q <= S_SHDN;
							end else if (full) begin
								st_q <= ST_FULL; ov_q <= 1'b1; len_q <= 9'(count_q);
								state_q <= S_IDLE;
							end else begin
								i_q <= count_q; state_q <= S_SHUP;
							end
						end else if (idx_q + 1'b1 == count_q) begin
							st_q <= ST_NOT_FOUND; ov_q <= 1'b1; len_q <= 9'(count_q);
							pend_q <= 1'b0; state_q <= S_IDLE;
						end else begin
							idx_q <= i_q; i_q <= i_q + 1'b1;
						end
					end else begin
						pend_q <= 1'b1;
						idx_q <= i_q;
						if (cmd_q != CMD_READ) i_q <= i_q + 1'b1;
					end
				end
				S_SHUP: begin
					if (i_q == idx_q) begin
						if (pend_q) begin
							pend_q <= 1'b0;
						end else begin
							count_q <= count_q + 1'b1; ov_q <= 1'b1;
							len_q <= 9'(count_q + 1'b1); state_q <= S_IDLE;
						end
					end else if (pend_q) begin
						i_q <= i_q - 1'b1;
						pend_q <= 1'b0;
					end else begin
						pend_q <= 1'b1;
					end
				end
				S_SHDN: begin
					if (pend_q) begin
						pend_q <= 1'b0; i_q <= i_q + 1'b1;
					end else if (i_q < count_q) begin
						pend_q <= 1'b1;
					end else begin
						count_q <= count_q - 1'b1; ov_q <= 1'b1;
						len_q <= 9'(count_q - 1'b1); state_q <= S_IDLE;
					end
				end
				S_REVA: begin
					state_q <= S_REVB;
				end
				S_REVB: begin
					hold_q <= rdata;
					pend_q <= 1'b1;
					state_q <= S_READ;
				end
				S_READ: begin
					// write b's value to i, then hold_q to j
					if (pend_q) begin
						pend_q <= 1'b0; hold_q <= hold_q;
					end else begin
						if (i_q + 1'b1 >= j_q - 1'b1 || j_q == i_q + 1'b1) begin
							ov_q <= 1'b1; len_q <= 9'(count_q); state_q <= S_IDLE;
						end else begin
							state_q <= S_REVA;
						end
						i_q <= i_q + 1'b1; j_q <= j_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sv/ordered_list_engine_core.sv]
// Top level of the ordered list engine: sequencer plus entry memory.
// Throughput: one request at a time; shifts read and then write each entry moved,
// scans compare one entry per cycle, reverse reads both entries of a swap, then writes them back.
// Reset: arst_n clears the count and control; entry memory is not cleared.
module ordered_list_engine_core import ole_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [8:0]  position,
	input  logic [31:0] value,
	input  logic [31:0] target_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  found_index,
	output logic [31:0] read_value,
	output logic [8:0]  length
);
	mem_req_t    mreq;
	logic [31:0] rdata;

	ole_seq u_seq (.*);
	ole_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));

	// Hold a stalled result and its payload until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_index)
			&& $stable(read_value) && $stable(length));
	// Hold off new requests while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall);
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FULL);
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> length <= 9'(CAPACITY));
endmodule

[tb/tb_ordered_list_engine_core.sv]
// Self-checking testbench for the ordered list engine top level.
module tb_ordered_list_engine_core;
	import ole_pkg::*;

	typedef struct {
		logic [3:0]  command;
		logic [8:0]  position;
		logic [31:0] value;
		logic [31:0] target_value;
	} list_request_t;

	typedef struct {
		logic [2:0]  status;
		logic [7:0]  found_index;
		logic [31:0] read_value;
		logic [8:0]  length;
	} list_reply_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  command;
	logic [8:0]  position;
	logic [31:0] value;
	logic [31:0] target_value;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [7:0]  found_index;
	logic [31:0] read_value;
	logic [8:0]  length;

	ordered_list_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .position(position), .value(value),
		.target_value(target_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found_index(found_index),
		.read_value(read_value), .length(length)
	);

	// Shadow copy of the list contents and count.
	logic [31:0] shadow_list [CAPACITY];
	int unsigned shadow_count;

	list_request_t pending_requests [$];
	list_reply_t   expected_replies [$];
	int unsigned   failures;
	bit            stimulus_done;
	bit            quiet_phase;
	int unsigned   send_idle;
	int unsigned   recv_idle;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Index of the first entry equal to v, or the count when absent.
	function automatic int unsigned find_first(logic [31:0] v);
		for (int unsigned i = 0; i < shadow_count; i++)
			if (shadow_list[i] == v)
				return i;
		return shadow_count;
	endfunction

	function automatic logic [2:0] shadow_insert(int unsigned idx, logic [31:0] v);
		if (idx > shadow_count)
			return ST_BAD_INDEX;
		if (shadow_count >= CAPACITY)
			return ST_FULL;
		for (int i = int'(shadow_count); i > int'(idx); i--)
			shadow_list[i] = shadow_list[i-1];
		shadow_list[idx] = v;
		shadow_count++;
		return ST_OK;
	endfunction

	function automatic logic [2:0] shadow_remove(int unsigned idx);
		if (idx >= shadow_count)
			return ST_BAD_INDEX;
		for (int unsigned i = idx; i + 1 < shadow_count; i++)
			shadow_list[i] = shadow_list[i+1];
		shadow_count--;
		return ST_OK;
	endfunction

	// Apply one request to the shadow list and return the reply it must give.
	function automatic list_reply_t apply_list_command(list_request_t r);
		list_reply_t rep;
		int unsigned k;
		logic [31:0] t;
		rep.status = ST_OK;
		rep.found_index = '0;
		rep.read_value = '0;
		case (r.command)
			CMD_INS_FIRST: rep.status = shadow_insert(0, r.value);
			CMD_INS_LAST: rep.status = shadow_insert(shadow_count, r.value);
			CMD_INS_AT: rep.status = shadow_insert(r.position, r.value);
			CMD_INS_BEFORE: begin
				k = find_first(r.target_value);
				rep.status = (k == shadow_count) ? ST_NOT_FOUND : shadow_insert(k, r.value);
			end
			CMD_DEL_FIRST: rep.status = (shadow_count == 0) ? ST_EMPTY : shadow_remove(0);
			CMD_DEL_LAST:
				rep.status = (shadow_count == 0) ? ST_EMPTY : shadow_remove(shadow_count - 1);
			CMD_DEL_AT: rep.status = shadow_remove(r.position);
			CMD_DEL_VALUE: begin
				k = find_first(r.value);
				rep.status = (k == shadow_count) ? ST_NOT_FOUND : shadow_remove(k);
			end
			CMD_FIND: begin
				k = find_first(r.value);
				if (k == shadow_count)
					rep.status = ST_NOT_FOUND;
				else
					rep.found_index = k[7:0];
			end
			CMD_READ: begin
				if (r.position >= shadow_count)
					rep.status = ST_BAD_INDEX;
				else
					rep.read_value = shadow_list[r.position];
			end
			CMD_REVERSE: begin
				for (int unsigned a = 0; a < shadow_count / 2; a++) begin
					t = shadow_list[a];
					shadow_list[a] = shadow_list[shadow_count-1-a];
					shadow_list[shadow_count-1-a] = t;
				end
			end
			CMD_CLEAR: shadow_count = 0;
			default: ;
		endcase
		rep.length = shadow_count[8:0];
		return rep;
	endfunction

	function automatic void queue_request(logic [3:0] cmd, logic [8:0] pos,
			logic [31:0] v, logic [31:0] tgt);
		list_request_t r;
		r.command = cmd;
		r.position = pos;
		r.value = v;
		r.target_value = tgt;
		pending_requests.push_back(r);
	endfunction

	// Draw values from a small pool most of the time so searches hit.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// Keep positions mostly near the live range, sometimes anywhere.
	function automatic logic [8:0] pick_position(int unsigned approx_count);
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 511);
		return $urandom_range(0, approx_count + 1);
	endfunction

	// Driver: present the next request, hold it while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= '0;
			position <= '0;
			value <= '0;
			target_value <= '0;
			send_idle <= 0;
		end else begin
			automatic bit taken = in_valid && !in_stall;
			automatic list_request_t r;
			if (taken)
				expected_replies.push_back(apply_list_command(pending_requests.pop_front()));
			if (in_valid && !taken) begin
				// hold while stalled
			end else if (send_idle > 0) begin
				in_valid <= 1'b0;
				send_idle <= send_idle - 1;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				send_idle <= $urandom_range(0, 6);
			end else if (pending_requests.size() > 0) begin
				r = pending_requests[0];
				in_valid <= 1'b1;
				command <= r.command;
				position <= r.position;
				value <= r.value;
				target_value <= r.target_value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each reply against the oldest expectation; stall in bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_idle <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected reply: status %0d length %0d", status, length);
					failures++;
				end else begin
					automatic list_reply_t e = expected_replies.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d actual %0d", e.status, status);
						failures++;
					end
					if (found_index !== e.found_index) begin
						$error("found_index: expected %0d actual %0d", e.found_index, found_index);
						failures++;
					end
					if (read_value !== e.read_value) begin
						$error("read_value: expected %h actual %h", e.read_value, read_value);
						failures++;
					end
					if (length !== e.length) begin
						$error("length: expected %0d actual %0d", e.length, length);
						failures++;
					end
				end
			end
			if (recv_idle > 0) begin
				out_stall <= 1'b1;
				recv_idle <= recv_idle - 1;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				recv_idle <= $urandom_range(0, 6);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned approx;
		failures = 0;
		stimulus_done = 0;
		quiet_phase = 0;
		shadow_count = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		command = '0;
		position = '0;
		value = '0;
		target_value = '0;

		// Directed: empty-store cases, every command, field extremes.
		queue_request(CMD_DEL_FIRST, 0, 0, 0);
		queue_request(CMD_DEL_LAST, 0, 0, 0);
		queue_request(CMD_DEL_AT, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0);
		queue_request(CMD_DEL_VALUE, 0, 5, 0);
		queue_request(CMD_FIND, 0, 5, 0);
		queue_request(CMD_REVERSE, 0, 0, 0);
		queue_request(CMD_CLEAR, 0, 0, 0);
		queue_request(CMD_INS_AT, 1, 7, 0);
		queue_request(CMD_INS_FIRST, 0, 32'h8000_0000, 0);
		queue_request(CMD_INS_LAST, 0, 32'h7fff_ffff, 0);
		queue_request(CMD_INS_AT, 2, 32'hffff_ffff, 0);
		queue_request(CMD_INS_AT, 9'h1ff, 1, 0);
		queue_request(CMD_INS_BEFORE, 0, 3, 32'h7fff_ffff);
		queue_request(CMD_INS_BEFORE, 0, 3, 32'h1234_5678);
		queue_request(CMD_FIND, 0, 32'hffff_ffff, 0);
		queue_request(CMD_READ, 3, 0, 0);
		queue_request(CMD_READ, 9'h1ff, 0, 0);
		queue_request(CMD_REVERSE, 0, 0, 0);
		queue_request(CMD_READ, 0, 0, 0);
		queue_request(CMD_DEL_VALUE, 0, 32'h8000_0000, 0);
		queue_request(CMD_DEL_AT, 9'h1ff, 0, 0);
		queue_request(CMD_DEL_AT, 1, 0, 0);
		queue_request(4'd12, 9'h155, 32'h5555_5555, 32'haaaa_aaaa);
		queue_request(4'd15, 9'h0aa, 32'haaaa_aaaa, 32'h5555_5555);

		// Fill to capacity and probe the full store, then clear.
		for (int i = 0; i < CAPACITY; i++)
			queue_request(CMD_INS_LAST, 0, i, 0);
		queue_request(CMD_INS_FIRST, 0, 1, 0);
		queue_request(CMD_INS_AT, 9'h1ff, 1, 0);
		queue_request(CMD_INS_AT, 9'd256, 1, 0);
		queue_request(CMD_INS_BEFORE, 0, 1, 32'h7777_7777);
		queue_request(CMD_INS_BEFORE, 0, 1, 32'd255);
		queue_request(CMD_FIND, 0, 32'd255, 0);
		queue_request(CMD_READ, 9'd255, 0, 0);
		queue_request(CMD_REVERSE, 0, 0, 0);
		queue_request(CMD_DEL_VALUE, 0, 32'd0, 0);
		queue_request(CMD_CLEAR, 0, 0, 0);

		// Random: list stays mostly short; approx tracks the count loosely.
		approx = 0;
		for (int n = 0; n < 2000; n++) begin
			automatic logic [3:0] c;
			if ($urandom_range(0, 199) == 0)
				c = CMD_CLEAR;
			else if ($urandom_range(0, 49) == 0)
				c = $urandom_range(12, 15);
			else if (approx < 4 || (approx < 40 && $urandom_range(0, 1) == 0))
				c = $urandom_range(0, 3);
			else
				c = $urandom_range(4, 10);
			case (c)
				CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT, CMD_INS_BEFORE: approx++;
				CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT, CMD_DEL_VALUE:
					if (approx > 0) approx--;
				CMD_CLEAR: approx = 0;
				default: ;
			endcase
			queue_request(c, pick_position(approx), pick_value(), pick_value());
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_requests.size() < 200);
		quiet_phase = 1;
		wait (pending_requests.size() == 0 && expected_replies.size() == 0);
		repeat (1100) @(posedge clk);
		if (failures == 0 && expected_replies.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Generous limit for ~2300 requests, stalls included.
	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end
endmodule
